/* design/gdc_pkg.sv */
// Shared types, constants and calendar tables for the Gregorian date calculator.
// No dependencies; used by gdc_date_eval and gregorian_date_calculator_core.
package gdc_pkg;

  localparam logic [13:0] MaxYear   = 14'd9999;
  localparam logic [3:0]  MonthJan  = 4'd1;
  localparam logic [3:0]  MonthFeb  = 4'd2;
  localparam logic [3:0]  MonthDec  = 4'd12;
  localparam logic [4:0]  DaysDec   = 5'd31;
  localparam logic [13:0] Recip100  = 14'd5243;   // 2^19 / 100, rounded up
  localparam int          Recip100Sh = 19;
  localparam logic [8:0]  Recip7    = 9'd293;     // 2^11 / 7, rounded up
  localparam int          Recip7Sh  = 11;

  typedef struct packed {
    logic        valid;
    logic        leap;
    logic [4:0]  dim;
    logic [8:0]  doy;
    logic [21:0] day_num;
  } date_info_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    unique case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

/* design/gdc_date_eval.sv */
// Per-date evaluation: validity, leap year, month length, day of year, day number.
// Depends on gdc_pkg.
module gdc_date_eval (
  input  logic [4:0]          day,
  input  logic [3:0]          month,
  input  logic [13:0]         year,
  output gdc_pkg::date_info_t info
);
  import gdc_pkg::*;

  logic [26:0] q_prod;
  logic [7:0]  q100;
  logic [13:0] q100_x100;
  logic        div100;
  logic        div400;
  logic        leap;
  logic [4:0]  dim;
  logic [8:0]  doy;
  logic [22:0] prior_days;
  logic [22:0] ceil4;
  logic [22:0] ceil100;
  logic [22:0] ceil400;
  logic [22:0] num;

  assign q_prod    = 27'(year) * 27'(Recip100);
  assign q100      = q_prod[Recip100Sh +: 8];
  assign q100_x100 = 14'(q100) * 14'd100;
  assign div100    = (q100_x100 == year);
  assign div400    = div100 && (q100[1:0] == 2'd0);
  assign leap      = ((year[1:0] == 2'd0) && !div100) || div400;

  assign dim = month_days(month, leap);
  assign doy = month_start(month) + 9'(day)
             + 9'((month > MonthFeb) && leap);

  assign ceil4      = 23'((15'(year) + 15'd3) >> 2);
  assign ceil100    = 23'(q100) + 23'(!div100);
  assign ceil400    = 23'(q100[7:2]) + 23'(!div400);
  assign prior_days = 23'(year) * 23'd365 + ceil4 - ceil100 + ceil400;
  assign num        = prior_days + 23'(doy);

  assign info.valid   = (year <= MaxYear) && (month >= MonthJan) && (month <= MonthDec)
                      && (day != 5'd0) && (day <= dim);
  assign info.leap    = leap;
  assign info.dim     = dim;
  assign info.doy     = doy;
  assign info.day_num = num[21:0];

endmodule

/* design/gregorian_date_calculator_core.sv */
// Top level of the Gregorian date calculator: input stage, result stage, handshake.
// Depends on gdc_pkg and gdc_date_eval.
//
// Each transfer carries two dates; one result follows for each. An accepted item
// is held in an input register, evaluated by one pass of combinational logic (two
// date evaluators, next/previous day, week of year, day difference) and captured
// in the result register, and a new item is taken
// every cycle while the result side keeps up. in_ready falls only when both
// stages are full and out_ready is low. Year 0 counts as leap; valid years are
// 0 to 9999. Invalid dates give step_ok 0, 1 January year 0 as neighbors, week 0
// and a zero difference.
module gregorian_date_calculator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  input  logic [4:0]  in_other_day,
  input  logic [3:0]  in_other_month,
  input  logic [13:0] in_other_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_date_valid,
  output logic        out_other_valid,
  output logic        out_leap_year,
  output logic [4:0]  out_next_day,
  output logic [3:0]  out_next_month,
  output logic [13:0] out_next_year,
  output logic [4:0]  out_prev_day,
  output logic [3:0]  out_prev_month,
  output logic [13:0] out_prev_year,
  output logic        out_step_ok,
  output logic [21:0] out_day_difference,
  output logic [5:0]  out_week_of_year
);
  import gdc_pkg::*;

  logic        s1_valid_r;
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic [4:0]  oday_r;
  logic [3:0]  omonth_r;
  logic [13:0] oyear_r;

  logic        out_valid_r;
  logic        date_valid_r, other_valid_r, leap_r, step_ok_r;
  logic [4:0]  next_day_r, prev_day_r;
  logic [3:0]  next_month_r, prev_month_r;
  logic [13:0] next_year_r, prev_year_r;
  logic [21:0] diff_r;
  logic [5:0]  week_r;

  date_info_t  a_info, b_info;
  logic        s2_take;
  logic        s1_take;

  logic        date_valid_nxt, other_valid_nxt, leap_nxt, step_ok_nxt;
  logic [4:0]  next_day_nxt, prev_day_nxt;
  logic [3:0]  next_month_nxt, prev_month_nxt;
  logic [13:0] next_year_nxt, prev_year_nxt;
  logic [21:0] diff_nxt;
  logic [5:0]  week_nxt;
  logic [17:0] week_prod;

  assign s2_take  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_take;
  assign s1_take  = in_valid && in_ready;

  gdc_date_eval u_eval_a (
    .day   (day_r),
    .month (month_r),
    .year  (year_r),
    .info  (a_info)
  );

  gdc_date_eval u_eval_b (
    .day   (oday_r),
    .month (omonth_r),
    .year  (oyear_r),
    .info  (b_info)
  );

  assign week_prod = 18'(a_info.doy) * 18'(Recip7);

  always_comb begin
    date_valid_nxt  = a_info.valid;
    other_valid_nxt = b_info.valid;
    leap_nxt        = a_info.leap;
    step_ok_nxt     = a_info.valid;
    next_day_nxt    = 5'd1;
    next_month_nxt  = MonthJan;
    next_year_nxt   = 14'd0;
    prev_day_nxt    = 5'd1;
    prev_month_nxt  = MonthJan;
    prev_year_nxt   = 14'd0;
    week_nxt        = 6'd0;
    diff_nxt        = 22'd0;
    if (a_info.valid) begin
      priority if (day_r < a_info.dim) begin
        next_day_nxt   = day_r + 5'd1;
        next_month_nxt = month_r;
        next_year_nxt  = year_r;
      end else if (month_r < MonthDec) begin
        next_month_nxt = month_r + 4'd1;
        next_year_nxt  = year_r;
      end else if (year_r < MaxYear) begin
        next_year_nxt  = year_r + 14'd1;
      end else begin
        step_ok_nxt    = 1'b0;
      end

      priority if (day_r > 5'd1) begin
        prev_day_nxt   = day_r - 5'd1;
        prev_month_nxt = month_r;
        prev_year_nxt  = year_r;
      end else if (month_r > MonthJan) begin
        prev_month_nxt = month_r - 4'd1;
        prev_day_nxt   = month_days(month_r - 4'd1, a_info.leap);
        prev_year_nxt  = year_r;
      end else if (year_r > 14'd0) begin
        prev_day_nxt   = DaysDec;
        prev_month_nxt = MonthDec;
        prev_year_nxt  = year_r - 14'd1;
      end else begin
        step_ok_nxt    = 1'b0;
      end

      week_nxt = 6'(week_prod >> Recip7Sh) + 6'd1;
    end
    if (a_info.valid && b_info.valid) begin
      diff_nxt = (a_info.day_num >= b_info.day_num) ? a_info.day_num - b_info.day_num
                                                    : b_info.day_num - a_info.day_num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      day_r    <= in_day;
      month_r  <= in_month;
      year_r   <= in_year;
      oday_r   <= in_other_day;
      omonth_r <= in_other_month;
      oyear_r  <= in_other_year;
    end
    if (s2_take && s1_valid_r) begin
      date_valid_r  <= date_valid_nxt;
      other_valid_r <= other_valid_nxt;
      leap_r        <= leap_nxt;
      step_ok_r     <= step_ok_nxt;
      next_day_r    <= next_day_nxt;
      next_month_r  <= next_month_nxt;
      next_year_r   <= next_year_nxt;
      prev_day_r    <= prev_day_nxt;
      prev_month_r  <= prev_month_nxt;
      prev_year_r   <= prev_year_nxt;
      diff_r        <= diff_nxt;
      week_r        <= week_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_date_valid     = date_valid_r;
  assign out_other_valid    = other_valid_r;
  assign out_leap_year      = leap_r;
  assign out_next_day       = next_day_r;
  assign out_next_month     = next_month_r;
  assign out_next_year      = next_year_r;
  assign out_prev_day       = prev_day_r;
  assign out_prev_month     = prev_month_r;
  assign out_prev_year      = prev_year_r;
  assign out_step_ok        = step_ok_r;
  assign out_day_difference = diff_r;
  assign out_week_of_year   = week_r;

endmodule
